FILE: rtl/core/itp_pkg.sv
// Shared types, character constants and helpers for the infix-to-postfix unit.
// No dependencies; used by itp_front, itp_back and the top level.
package itp_pkg;

	// Operator codes as kept on the operator stack
	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	// ASCII characters the unit recognizes or produces
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NUL   = 8'h00;

	// Classified input character, as queued between front and back
	typedef struct packed {
		logic       is_digit;
		logic       is_op;
		logic [1:0] code;
		logic [7:0] ch;
		logic       last;
	} cmd_t;

	// One output character with its flags
	typedef struct packed {
		logic [7:0] ch;
		logic       eoe;
		logic       lor;
	} res_t;

	// Map an operator code back to its character
	function automatic logic [7:0] op_char(input logic [1:0] code);
		logic [7:0] c;
		case (code)
			OP_ADD:  c = CH_PLUS;
			OP_SUB:  c = CH_MINUS;
			OP_MUL:  c = CH_STAR;
			OP_DIV:  c = CH_SLASH;
			default: c = CH_PLUS;
		endcase
		return c;
	endfunction

	// True when priority of operator a is at most that of operator b
	function automatic logic prio_le(input logic [1:0] a, input logic [1:0] b);
		return !a[1] || b[1];
	endfunction

endpackage

FILE: rtl/core/infix_to_postfix_converter_unit.sv
// Channel   | Direction | Handshake     | Payload
// input     | in        | push / full   | in_char[7:0], last
// result    | out       | pop / empty   | out_char[7:0], end_of_expression, last_of_run
//
// The back-end sequencer emits one character a cycle while a command waits and the
// output queue has room, and sets the rate: a character takes one step per output
// character, one more for an operator push, and one more when its first step emits
// nothing (an ignored character, or an operator or last character that closes no
// number). A two-entry command queue separates front and back; a two-entry output
// queue lets the back end keep working while a result waits. Reset (arst_n) empties
// both queues, the operator stack and the open-number flag.
// Top level of the infix-to-postfix unit; uses itp_pkg, itp_front and itp_back.
module infix_to_postfix_converter_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] in_char,
	input  logic       last,
	input  logic       push,
	output logic       full,
	output logic [7:0] out_char,
	output logic       end_of_expression,
	output logic       last_of_run,
	output logic       empty,
	input  logic       pop
);

	logic          cmd_valid;
	logic          cmd_pop;
	itp_pkg::cmd_t cmd;
	itp_pkg::res_t res;

	// Accept and classify characters
	itp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_char   (in_char),
		.last      (last),
		.push      (push),
		.full      (full),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	// Run the conversion and queue output characters
	itp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.empty     (empty),
		.res       (res),
		.pop       (pop)
	);

	assign out_char          = res.ch;
	assign end_of_expression = res.eoe;
	assign last_of_run       = res.lor;

endmodule

FILE: rtl/core/itp_front.sv
// Front end: accepts input characters, classifies them and queues commands.
// Depends on itp_pkg for cmd_t and the character constants.
module itp_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         in_char,
	input  logic               last,
	input  logic               push,
	output logic               full,
	output logic               cmd_valid,
	output itp_pkg::cmd_t      cmd,
	input  logic               cmd_pop
);

	itp_pkg::cmd_t cls;
	itp_pkg::cmd_t q_q [2];
	logic          wp_q;
	logic          rp_q;
	logic [1:0]    cnt_q;
	logic          wr_en;
	logic          rd_en;

	// Classify the incoming character
	always_comb begin
		cls.is_digit = (in_char >= itp_pkg::CH_ZERO) && (in_char <= itp_pkg::CH_NINE);
		cls.is_op    = 1'b1;
		cls.code     = itp_pkg::OP_ADD;
		cls.ch       = in_char;
		cls.last     = last;
		case (in_char)
			itp_pkg::CH_PLUS:  cls.code = itp_pkg::OP_ADD;
			itp_pkg::CH_MINUS: cls.code = itp_pkg::OP_SUB;
			itp_pkg::CH_STAR:  cls.code = itp_pkg::OP_MUL;
			itp_pkg::CH_SLASH: cls.code = itp_pkg::OP_DIV;
			default:           cls.is_op = 1'b0;
		endcase
	end

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_q[rp_q];
	assign wr_en     = push && !full;
	assign rd_en     = cmd_pop && cmd_valid;

	// Store commands
	always_ff @(posedge clk) begin
		if (wr_en) begin
			q_q[wp_q] <= cls;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) begin
				wp_q <= !wp_q;
			end
			if (rd_en) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
		end
	end

endmodule

FILE: rtl/core/itp_back.sv
// Back end: runs the shunting-yard sequence for each command and queues characters.
// Depends on itp_pkg for cmd_t, res_t, constants and helpers.
module itp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  itp_pkg::cmd_t      cmd,
	output logic               cmd_pop,
	output logic               empty,
	output itp_pkg::res_t      res,
	input  logic               pop
);

	localparam logic [2:0] PH_MAIN  = 3'd0;
	localparam logic [2:0] PH_OPS   = 3'd1;
	localparam logic [2:0] PH_SP    = 3'd2;
	localparam logic [2:0] PH_FLUSH = 3'd3;
	localparam logic [2:0] PH_FSP   = 3'd4;

	logic [2:0]    phase_q;
	logic          innum_q;
	logic [1:0]    stk_cnt_q;
	logic [1:0]    stk_q [2];
	logic [1:0]    top;
	logic          popc;
	logic          popc_next;

	logic          go;
	logic          emit;
	logic          done;
	logic          push_en;
	logic          dec_en;
	itp_pkg::res_t er;
	logic [2:0]    nxt_phase;
	logic          nxt_innum;

	itp_pkg::res_t o_q [2];
	logic          owp_q;
	logic          orp_q;
	logic [1:0]    ocnt_q;
	logic          ofull;
	logic          o_wr;
	logic          o_rd;

	assign top       = stk_q[stk_cnt_q[1]];
	assign popc      = (stk_cnt_q != 2'd0) && itp_pkg::prio_le(cmd.code, top);
	assign popc_next = (stk_cnt_q == 2'd2) && itp_pkg::prio_le(cmd.code, stk_q[0]);
	assign ofull     = (ocnt_q == 2'd2);
	assign go        = cmd_valid && !ofull;

	// Pick this cycle's action
	always_comb begin
		emit      = 1'b0;
		done      = 1'b0;
		push_en   = 1'b0;
		dec_en    = 1'b0;
		er.ch     = itp_pkg::CH_SPACE;
		er.eoe    = 1'b0;
		er.lor    = 1'b0;
		nxt_phase = phase_q;
		nxt_innum = innum_q;
		case (phase_q)
			PH_MAIN: begin
				if (cmd.is_digit) begin
					emit      = 1'b1;
					er.ch     = cmd.ch;
					er.lor    = !cmd.last;
					nxt_innum = 1'b1;
					nxt_phase = PH_FLUSH;
					done      = !cmd.last;
				end else if (innum_q) begin
					emit      = 1'b1;
					er.lor    = !cmd.last && !(cmd.is_op && popc);
					nxt_innum = 1'b0;
					nxt_phase = cmd.is_op ? PH_OPS : PH_FLUSH;
					done      = !cmd.is_op && !cmd.last;
				end else if (cmd.is_op) begin
					nxt_phase = PH_OPS;
				end else begin
					nxt_phase = PH_FLUSH;
					done      = !cmd.last;
				end
			end
			PH_OPS: begin
				if (popc) begin
					emit      = 1'b1;
					er.ch     = itp_pkg::op_char(top);
					nxt_phase = PH_SP;
				end else begin
					push_en   = 1'b1;
					nxt_phase = PH_FLUSH;
					done      = !cmd.last;
				end
			end
			PH_SP: begin
				emit      = 1'b1;
				dec_en    = 1'b1;
				er.lor    = !cmd.last && !popc_next;
				nxt_phase = PH_OPS;
			end
			PH_FLUSH: begin
				emit = 1'b1;
				if (innum_q) begin
					nxt_innum = 1'b0;
				end else if (stk_cnt_q != 2'd0) begin
					er.ch     = itp_pkg::op_char(top);
					nxt_phase = PH_FSP;
				end else begin
					er.ch  = itp_pkg::CH_NUL;
					er.eoe = 1'b1;
					er.lor = 1'b1;
					done   = 1'b1;
				end
			end
			PH_FSP: begin
				emit      = 1'b1;
				dec_en    = 1'b1;
				nxt_phase = PH_FLUSH;
			end
			default: begin
				nxt_phase = PH_MAIN;
			end
		endcase
		if (done) begin
			nxt_phase = PH_MAIN;
		end
	end

	assign cmd_pop = go && done;

	// Hold sequencer state and the operator count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_MAIN;
			innum_q   <= 1'b0;
			stk_cnt_q <= 2'd0;
		end else if (go) begin
			phase_q <= nxt_phase;
			innum_q <= nxt_innum;
			if (dec_en) begin
				stk_cnt_q <= stk_cnt_q - 2'd1;
			end else if (push_en && (stk_cnt_q != 2'd2)) begin
				stk_cnt_q <= stk_cnt_q + 2'd1;
			end
		end
	end

	// Write pushed operators; a full stack overwrites its top
	always_ff @(posedge clk) begin
		if (go && push_en) begin
			if (stk_cnt_q == 2'd2) begin
				stk_q[1] <= cmd.code;
			end else begin
				stk_q[stk_cnt_q[0]] <= cmd.code;
			end
		end
	end

	assign o_wr  = go && emit;
	assign o_rd  = pop && !empty;
	assign empty = (ocnt_q == 2'd0);
	assign res   = o_q[orp_q];

	// Store output characters
	always_ff @(posedge clk) begin
		if (o_wr) begin
			o_q[owp_q] <= er;
		end
	end

	// Advance output queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q  <= 1'b0;
			orp_q  <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (o_wr) begin
				owp_q <= !owp_q;
			end
			if (o_rd) begin
				orp_q <= !orp_q;
			end
			ocnt_q <= ocnt_q + {1'b0, o_wr} - {1'b0, o_rd};
		end
	end

`ifndef SYNTHESIS
	// The operator stack never holds more than two entries
	a_stk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stk_cnt_q != 2'd3) else $error("operator stack overflow");

	// A terminator leaves the operator count, open-number flag and phase as after reset
	a_term_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(o_wr && er.eoe) |=> (stk_cnt_q == 2'd0) && !innum_q && (phase_q == PH_MAIN))
		else $error("state not cleared after terminator");

	// A terminator always closes its transaction's run
	a_term_lor: assert property (@(posedge clk) disable iff (!arst_n)
		(o_wr && er.eoe) |-> (er.lor && cmd_pop))
		else $error("terminator not final in run");

	// A command retires only once it is present, and never from PH_SP or PH_FSP
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> (cmd_valid && (phase_q != PH_SP) && (phase_q != PH_FSP)))
		else $error("command retired from bad phase");
`endif

endmodule
